// ===== rtl/core/lfpc_pkg.sv =====
// Package for the length-framed packet checker: field widths, status and
// kind codes, register indexes and frame-size constants.
// Depends on nothing; every other file of the block takes names from it.
package lfpc_pkg;

	// Field widths.
	localparam int unsigned BYTE_W      = 8;
	localparam int unsigned COUNT_W     = 17;
	localparam int unsigned MAGIC_W     = 32;
	localparam int unsigned ID_W        = 16;
	localparam int unsigned SEQ_W       = 32;
	localparam int unsigned LEN_W       = 16;
	localparam int unsigned SUM_W       = 16;
	localparam int unsigned STATUS_W    = 3;
	localparam int unsigned CFG_INDEX_W = 1;
	localparam int unsigned CFG_DATA_W  = 32;

	// Frame layout.
	localparam logic [COUNT_W-1:0] HEADER_BYTES = COUNT_W'(12);
	localparam logic [COUNT_W-1:0] MIN_FRAME    = COUNT_W'(14);
	localparam logic [COUNT_W-1:0] COUNT_MAX    = {COUNT_W{1'b1}};

	// Register reset values.
	localparam logic [MAGIC_W-1:0] MAGIC_RESET        = '0;
	localparam logic [LEN_W-1:0]   MAX_DATAGRAM_RESET = LEN_W'(65507);

	// Configuration register indexes.
	localparam logic [CFG_INDEX_W-1:0] REG_MAGIC_WORD   = CFG_INDEX_W'(0);
	localparam logic [CFG_INDEX_W-1:0] REG_MAX_DATAGRAM = CFG_INDEX_W'(1);

	// Result kinds.
	localparam logic KIND_PAYLOAD = 1'b0;
	localparam logic KIND_STATUS  = 1'b1;

	// Frame verdicts.
	localparam logic [STATUS_W-1:0] STATUS_OK        = 3'd0;
	localparam logic [STATUS_W-1:0] STATUS_SHORT     = 3'd1;
	localparam logic [STATUS_W-1:0] STATUS_LONG      = 3'd2;
	localparam logic [STATUS_W-1:0] STATUS_BAD_MAGIC = 3'd3;
	localparam logic [STATUS_W-1:0] STATUS_LENGTH    = 3'd4;
	localparam logic [STATUS_W-1:0] STATUS_CHECKSUM  = 3'd5;

endpackage

// ===== rtl/core/lfpc_if.sv =====
// Channel interfaces of the length-framed packet checker: the byte input,
// the result output and the configuration write channel.
// Depends on lfpc_pkg for the field widths.
interface lfpc_byte_if;
	logic                          valid;
	logic                          ready;
	logic [lfpc_pkg::BYTE_W-1:0]   byte_value;
	logic                          frame_end;

	modport source (output valid, byte_value, frame_end, input ready);
	modport sink   (input valid, byte_value, frame_end, output ready);
endinterface

interface lfpc_result_if;
	logic                            valid;
	logic                            ready;
	logic                            kind;
	logic [lfpc_pkg::BYTE_W-1:0]     data_byte;
	logic [lfpc_pkg::ID_W-1:0]       msg_ident;
	logic [lfpc_pkg::SEQ_W-1:0]      sequence_number;
	logic [lfpc_pkg::LEN_W-1:0]      payload_length;
	logic [lfpc_pkg::STATUS_W-1:0]   status;

	modport source (output valid, kind, data_byte, msg_ident, sequence_number,
		payload_length, status, input ready);
	modport sink   (input valid, kind, data_byte, msg_ident, sequence_number,
		payload_length, status, output ready);
endinterface

interface lfpc_cfg_if;
	logic                              valid;
	logic                              ready;
	logic [lfpc_pkg::CFG_INDEX_W-1:0]  index;
	logic [lfpc_pkg::CFG_DATA_W-1:0]   data;

	modport source (output valid, index, data, input ready);
	modport sink   (input valid, index, data, output ready);
endinterface

// ===== rtl/core/length_framed_packet_checker_unit.sv =====
// Results are registered; the output register is refilled in the cycle it drains.
// Throughput: one byte per cycle while the output register is empty or drains.
// A payload byte appears once the following non-final byte is taken; the final byte
// gives the status transaction. Reset (arst_n low) clears the frame state, empties the
// output register and restores magic_word to 0 and max_datagram to 65507.
// Top level of the length-framed packet checker; uses lfpc_pkg and lfpc_if.
module length_framed_packet_checker_unit (
	input  logic                 clk,
	input  logic                 arst_n,
	lfpc_byte_if.sink            bytes,
	lfpc_result_if.source        results,
	lfpc_cfg_if.sink             cfg
);

	// Configuration registers.
	logic [lfpc_pkg::MAGIC_W-1:0] magic_word_q;
	logic [lfpc_pkg::LEN_W-1:0]   max_datagram_q;

	// Frame state.
	logic [lfpc_pkg::COUNT_W-1:0] byte_count_q;
	logic [lfpc_pkg::MAGIC_W-1:0] magic_seen_q;
	logic [lfpc_pkg::ID_W-1:0]    id_seen_q;
	logic [lfpc_pkg::SEQ_W-1:0]   sequence_seen_q;
	logic [lfpc_pkg::LEN_W-1:0]   length_seen_q;
	logic [lfpc_pkg::SUM_W-1:0]   lagged_sum_q;
	logic [lfpc_pkg::BYTE_W-1:0]  held_older_q;
	logic [lfpc_pkg::BYTE_W-1:0]  held_newer_q;

	// Output register.
	logic                          res_valid_q;
	logic                          kind_q;
	logic [lfpc_pkg::BYTE_W-1:0]   data_byte_q;
	logic [lfpc_pkg::ID_W-1:0]     msg_ident_q;
	logic [lfpc_pkg::SEQ_W-1:0]    sequence_q;
	logic [lfpc_pkg::LEN_W-1:0]    payload_length_q;
	logic [lfpc_pkg::STATUS_W-1:0] status_q;

	// Combinational values for the byte in flight.
	logic                          accept;
	logic [lfpc_pkg::COUNT_W-1:0]  total;
	logic [lfpc_pkg::MAGIC_W-1:0]  magic_nx;
	logic [lfpc_pkg::ID_W-1:0]     id_nx;
	logic [lfpc_pkg::SEQ_W-1:0]    sequence_nx;
	logic [lfpc_pkg::LEN_W-1:0]    length_nx;
	logic [lfpc_pkg::SUM_W-1:0]    computed_sum;
	logic [lfpc_pkg::SUM_W-1:0]    received_sum;
	logic [lfpc_pkg::STATUS_W-1:0] verdict;
	logic                          emit_payload;

	// A byte is taken whenever the output register is empty or drains now.
	assign bytes.ready = !res_valid_q || results.ready;
	assign accept      = bytes.valid && bytes.ready;
	assign cfg.ready   = 1'b1;

	// Saturating frame length including this byte.
	assign total = (byte_count_q == lfpc_pkg::COUNT_MAX) ? byte_count_q
		: byte_count_q + lfpc_pkg::COUNT_W'(1);

	// Merge the current byte into the header field that its position selects.
	always_comb begin
		magic_nx    = magic_seen_q;
		id_nx       = id_seen_q;
		sequence_nx = sequence_seen_q;
		length_nx   = length_seen_q;
		if (byte_count_q < lfpc_pkg::COUNT_W'(4)) begin
			magic_nx[8*byte_count_q[1:0] +: 8] = bytes.byte_value;
		end else if (byte_count_q < lfpc_pkg::COUNT_W'(6)) begin
			id_nx[8*(byte_count_q[0]) +: 8] = bytes.byte_value;
		end else if (byte_count_q < lfpc_pkg::COUNT_W'(10)) begin
			sequence_nx[8*(2'(byte_count_q[1:0] - 2'd2)) +: 8] = bytes.byte_value;
		end else if (byte_count_q < lfpc_pkg::HEADER_BYTES) begin
			length_nx[8*(byte_count_q[0]) +: 8] = bytes.byte_value;
		end
	end

	// Checksum: the trailing two bytes against the sum of all earlier ones.
	assign computed_sum = lagged_sum_q + lfpc_pkg::SUM_W'(held_older_q);
	assign received_sum = {bytes.byte_value, held_newer_q};

	// Verdict, first failing check wins.
	always_comb begin
		priority if (total < lfpc_pkg::MIN_FRAME) begin
			verdict = lfpc_pkg::STATUS_SHORT;
		end else if (total > {1'b0, max_datagram_q}) begin
			verdict = lfpc_pkg::STATUS_LONG;
		end else if (magic_nx != magic_word_q) begin
			verdict = lfpc_pkg::STATUS_BAD_MAGIC;
		end else if (total != lfpc_pkg::MIN_FRAME + {1'b0, length_nx}) begin
			verdict = lfpc_pkg::STATUS_LENGTH;
		end else if (received_sum != computed_sum) begin
			verdict = lfpc_pkg::STATUS_CHECKSUM;
		end else begin
			verdict = lfpc_pkg::STATUS_OK;
		end
	end

	// The held newer byte is payload once a later non-final byte arrives.
	assign emit_payload = !bytes.frame_end
		&& (byte_count_q > lfpc_pkg::HEADER_BYTES);

	// Configuration writes.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			magic_word_q   <= lfpc_pkg::MAGIC_RESET;
			max_datagram_q <= lfpc_pkg::MAX_DATAGRAM_RESET;
		end else if (cfg.valid && cfg.ready) begin
			unique case (cfg.index)
				lfpc_pkg::REG_MAGIC_WORD: begin
					magic_word_q <= cfg.data;
				end
				lfpc_pkg::REG_MAX_DATAGRAM: begin
					max_datagram_q <= cfg.data[lfpc_pkg::LEN_W-1:0];
				end
				default: begin
				end
			endcase
		end
	end

	// Frame state: advanced on every byte, cleared after the final one.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			byte_count_q    <= '0;
			magic_seen_q    <= '0;
			id_seen_q       <= '0;
			sequence_seen_q <= '0;
			length_seen_q   <= '0;
			lagged_sum_q    <= '0;
			held_older_q    <= '0;
			held_newer_q    <= '0;
		end else if (accept) begin
			if (bytes.frame_end) begin
				byte_count_q    <= '0;
				magic_seen_q    <= '0;
				id_seen_q       <= '0;
				sequence_seen_q <= '0;
				length_seen_q   <= '0;
				lagged_sum_q    <= '0;
				held_older_q    <= '0;
				held_newer_q    <= '0;
			end else begin
				byte_count_q    <= total;
				magic_seen_q    <= magic_nx;
				id_seen_q       <= id_nx;
				sequence_seen_q <= sequence_nx;
				length_seen_q   <= length_nx;
				lagged_sum_q    <= computed_sum;
				held_older_q    <= held_newer_q;
				held_newer_q    <= bytes.byte_value;
			end
		end
	end

	// Output register valid flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (accept && (bytes.frame_end || emit_payload)) begin
			res_valid_q <= 1'b1;
		end else if (results.ready) begin
			res_valid_q <= 1'b0;
		end
	end

	// Output register payload.
	always_ff @(posedge clk) begin
		if (accept && bytes.frame_end) begin
			kind_q           <= lfpc_pkg::KIND_STATUS;
			data_byte_q      <= '0;
			msg_ident_q      <= id_nx;
			sequence_q       <= sequence_nx;
			payload_length_q <= length_nx;
			status_q         <= verdict;
		end else if (accept && emit_payload) begin
			kind_q           <= lfpc_pkg::KIND_PAYLOAD;
			data_byte_q      <= held_newer_q;
			msg_ident_q      <= '0;
			sequence_q       <= '0;
			payload_length_q <= '0;
			status_q         <= lfpc_pkg::STATUS_OK;
		end
	end

	assign results.valid           = res_valid_q;
	assign results.kind            = kind_q;
	assign results.data_byte       = data_byte_q;
	assign results.msg_ident       = msg_ident_q;
	assign results.sequence_number = sequence_q;
	assign results.payload_length  = payload_length_q;
	assign results.status          = status_q;

`ifndef SYNTHESIS
	// The frame state restarts after every final byte.
	a_count_clears: assert property (@(posedge clk) disable iff (!arst_n)
		accept && bytes.frame_end |=> byte_count_q == '0)
		else $error("byte count not cleared after frame end");

	// A non-final byte past the first payload byte releases a payload transaction.
	a_payload_emitted: assert property (@(posedge clk) disable iff (!arst_n)
		accept && !bytes.frame_end && (byte_count_q > lfpc_pkg::HEADER_BYTES)
		|=> res_valid_q && kind_q == lfpc_pkg::KIND_PAYLOAD)
		else $error("payload byte not emitted");

	// The count never moves backwards within a frame.
	a_count_monotonic: assert property (@(posedge clk) disable iff (!arst_n)
		accept && !bytes.frame_end |=> byte_count_q >= $past(byte_count_q))
		else $error("byte count went backwards");

	// A final byte always yields a status transaction.
	a_status_emitted: assert property (@(posedge clk) disable iff (!arst_n)
		accept && bytes.frame_end |=> res_valid_q && kind_q == lfpc_pkg::KIND_STATUS)
		else $error("status transaction missing after frame end");
`endif

endmodule

// ===== test/lfpc_frame_model_pkg.sv =====
`timescale 1ns / 100ps
// Result type and frame outcome tracker for the length-framed packet checker bench.
// The tracker mirrors the checker's frame state and holds the results still awaited.
// Depends on lfpc_pkg for widths, register indexes, kinds and verdict codes.
package lfpc_frame_model_pkg;
	import lfpc_pkg::*;

	// One result transaction as seen on the output channel.
	typedef struct packed {
		logic                kind;
		logic [BYTE_W-1:0]   data_byte;
		logic [ID_W-1:0]     msg_ident;
		logic [SEQ_W-1:0]    sequence_number;
		logic [LEN_W-1:0]    payload_length;
		logic [STATUS_W-1:0] status;
	} lfpc_result_t;

	class frame_outcome_tracker;
		// Register copies.
		logic [MAGIC_W-1:0] magic_word;
		logic [LEN_W-1:0]   max_datagram;

		// Frame state.
		logic [COUNT_W-1:0] bytes_in_frame;
		logic [MAGIC_W-1:0] hdr_magic;
		logic [ID_W-1:0]    hdr_id;
		logic [SEQ_W-1:0]   hdr_seq;
		logic [LEN_W-1:0]   hdr_len;
		logic [SUM_W-1:0]   sum_to_older;
		logic [BYTE_W-1:0]  byte_older;
		logic [BYTE_W-1:0]  byte_newer;

		lfpc_result_t awaited_results[$];
		int unsigned  failures;
		int unsigned  payload_seen;
		int unsigned  verdict_tally[8];

		function new();
			magic_word   = MAGIC_RESET;
			max_datagram = MAX_DATAGRAM_RESET;
			failures     = 0;
			payload_seen = 0;
			foreach (verdict_tally[i]) verdict_tally[i] = 0;
			clear_frame();
		endfunction

		function void clear_frame();
			bytes_in_frame = '0;
			hdr_magic      = '0;
			hdr_id         = '0;
			hdr_seq        = '0;
			hdr_len        = '0;
			sum_to_older   = '0;
			byte_older     = '0;
			byte_newer     = '0;
		endfunction

		function void write_register(logic [CFG_INDEX_W-1:0] index, logic [CFG_DATA_W-1:0] data);
			if (index == REG_MAGIC_WORD) begin
				magic_word = data[MAGIC_W-1:0];
			end else if (index == REG_MAX_DATAGRAM) begin
				max_datagram = data[LEN_W-1:0];
			end
		endfunction

		function int unsigned pending_count();
			return awaited_results.size();
		endfunction

		// Advances the frame state by one accepted byte and queues what it yields.
		function void take_byte(logic [BYTE_W-1:0] value, logic last);
			logic [COUNT_W-1:0]  total;
			logic [SUM_W-1:0]    computed;
			logic [SUM_W-1:0]    received;
			logic [STATUS_W-1:0] verdict;
			lfpc_result_t        r;
			int unsigned         p;
			p = bytes_in_frame;
			total = (bytes_in_frame < COUNT_MAX) ? bytes_in_frame + 1'b1 : COUNT_MAX;

			// Header capture, little-endian.
			if (p < 4) begin
				hdr_magic[8*p +: BYTE_W] = value;
			end else if (p < 6) begin
				hdr_id[8*(p-4) +: BYTE_W] = value;
			end else if (p < 10) begin
				hdr_seq[8*(p-6) +: BYTE_W] = value;
			end else if (p < 12) begin
				hdr_len[8*(p-10) +: BYTE_W] = value;
			end

			r = '0;
			if (last) begin
				// Final byte: the last two bytes are the checksum, checked in priority order.
				computed = sum_to_older + SUM_W'(byte_older);
				received = {value, byte_newer};
				if (total < MIN_FRAME) begin
					verdict = STATUS_SHORT;
				end else if (total > COUNT_W'(max_datagram)) begin
					verdict = STATUS_LONG;
				end else if (hdr_magic != magic_word) begin
					verdict = STATUS_BAD_MAGIC;
				end else if (total != MIN_FRAME + COUNT_W'(hdr_len)) begin
					verdict = STATUS_LENGTH;
				end else if (received != computed) begin
					verdict = STATUS_CHECKSUM;
				end else begin
					verdict = STATUS_OK;
				end
				r.kind            = KIND_STATUS;
				r.msg_ident       = hdr_id;
				r.sequence_number = hdr_seq;
				r.payload_length  = hdr_len;
				r.status          = verdict;
				awaited_results.insert(awaited_results.size(), r);
				clear_frame();
			end else begin
				// A non-final byte releases the byte just before it as payload.
				if (bytes_in_frame >= HEADER_BYTES + 1'b1) begin
					r.kind      = KIND_PAYLOAD;
					r.data_byte = byte_newer;
					awaited_results.insert(awaited_results.size(), r);
				end
				sum_to_older   = sum_to_older + SUM_W'(byte_older);
				byte_older     = byte_newer;
				byte_newer     = value;
				bytes_in_frame = total;
			end
		endfunction

		function string describe(lfpc_result_t r);
			return $sformatf("kind %0d data %02h id %04h seq %08h len %04h status %0d",
				r.kind, r.data_byte, r.msg_ident, r.sequence_number, r.payload_length,
				r.status);
		endfunction

		function void report_failure(string what);
			failures++;
			if (failures <= 10) begin
				$display("ERROR at %0t: %s", $time, what);
			end
		endfunction

		// Compares one output transaction with the oldest awaited result.
		function void compare_result(lfpc_result_t got);
			lfpc_result_t want;
			if (awaited_results.size() == 0) begin
				report_failure({"unexpected result: ", describe(got)});
				return;
			end
			want = awaited_results.pop_front();
			if (got.kind !== want.kind || got.data_byte !== want.data_byte ||
					got.msg_ident !== want.msg_ident ||
					got.sequence_number !== want.sequence_number ||
					got.payload_length !== want.payload_length ||
					got.status !== want.status) begin
				report_failure({"expected ", describe(want), " / got ", describe(got)});
			end else if (want.kind == KIND_STATUS) begin
				verdict_tally[want.status]++;
			end else begin
				payload_seen++;
			end
		endfunction

		function void flush_leftovers();
			while (awaited_results.size() != 0) begin
				report_failure({"missing result: ", describe(awaited_results.pop_front())});
			end
		endfunction
	endclass

endpackage

// ===== test/tb_length_framed_packet_checker_unit.sv =====
`timescale 1ns / 100ps
// Testbench for length_framed_packet_checker_unit: directed and random datagrams under
// several register settings, with random gaps on both channels and a scoreboard check.
// Depends on lfpc_pkg, lfpc_if and lfpc_frame_model_pkg.
module tb_length_framed_packet_checker_unit;
	import lfpc_pkg::*;
	import lfpc_frame_model_pkg::*;

	typedef enum {
		SHAPE_GOOD,
		SHAPE_BAD_MAGIC,
		SHAPE_BAD_LENGTH,
		SHAPE_BAD_SUM,
		SHAPE_CUT,
		SHAPE_NOISE
	} frame_shape_t;

	logic clk;
	logic arst_n;

	lfpc_byte_if   bytes_ch ();
	lfpc_result_if result_ch ();
	lfpc_cfg_if    cfg_ch ();

	length_framed_packet_checker_unit u_dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.bytes   (bytes_ch),
		.results (result_ch),
		.cfg     (cfg_ch)
	);

	frame_outcome_tracker outcomes;
	logic [BYTE_W-1:0]    frame_q[$];
	logic [MAGIC_W-1:0]   cur_magic;
	bit                   quiet;
	int unsigned          settings_used;

	// Clock.
	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Hard limit on the run.
	initial begin
		#20_000_000;
		$display("Some tests failed");
		$finish;
	end

	// Appends one byte to the datagram under construction.
	function automatic void add_byte(input logic [BYTE_W-1:0] value);
		frame_q.insert(frame_q.size(), value);
	endfunction

	// Gap length: mostly none or short, now and then long.
	function automatic int idle_length();
		int r;
		r = $urandom_range(0, 99);
		if (r < 55) return 0;
		if (r < 85) return $urandom_range(1, 3);
		if (r < 97) return $urandom_range(4, 8);
		return $urandom_range(9, 30);
	endfunction

	function automatic void append_checksum();
		logic [SUM_W-1:0] sum;
		sum = '0;
		foreach (frame_q[i]) sum = sum + SUM_W'(frame_q[i]);
		add_byte(sum[7:0]);
		add_byte(sum[15:8]);
	endfunction

	// Builds one random datagram in frame_q, well formed most of the time.
	function automatic void build_frame();
		frame_shape_t       shape;
		int                 r;
		int                 len;
		int                 cut;
		logic [LEN_W-1:0]   declared;
		logic [MAGIC_W-1:0] magic;
		logic [ID_W-1:0]    id;
		logic [SEQ_W-1:0]   seq;
		bit                 fill_ones;
		r = $urandom_range(0, 99);
		shape = (r < 60) ? SHAPE_GOOD : (r < 68) ? SHAPE_BAD_MAGIC :
			(r < 76) ? SHAPE_BAD_LENGTH : (r < 84) ? SHAPE_BAD_SUM :
			(r < 92) ? SHAPE_CUT : SHAPE_NOISE;
		frame_q.delete();
		if (shape == SHAPE_NOISE) begin
			repeat ($urandom_range(1, 40)) add_byte(BYTE_W'($urandom));
			return;
		end

		// Mostly small payloads; a few long ones, some all ones so the sum wraps.
		len = ($urandom_range(0, 11) == 0) ? $urandom_range(25, 400) : $urandom_range(0, 24);
		fill_ones = ($urandom_range(0, 3) == 0);
		declared = LEN_W'(len);
		if (shape == SHAPE_BAD_LENGTH) begin
			case ($urandom_range(0, 2))
				0: declared = LEN_W'(len + $urandom_range(1, 3));
				1: declared = LEN_W'(len - 1);
				default: declared = LEN_W'($urandom);
			endcase
		end
		magic = cur_magic;
		if (shape == SHAPE_BAD_MAGIC) begin
			magic[$urandom_range(0, 31)] ^= 1'b1;
		end
		id  = ID_W'($urandom);
		seq = $urandom;

		for (int i = 0; i < 4; i++) add_byte(magic[8*i +: 8]);
		for (int i = 0; i < 2; i++) add_byte(id[8*i +: 8]);
		for (int i = 0; i < 4; i++) add_byte(seq[8*i +: 8]);
		for (int i = 0; i < 2; i++) add_byte(declared[8*i +: 8]);
		repeat (len) add_byte(fill_ones ? 8'hFF : BYTE_W'($urandom));
		append_checksum();

		if (shape == SHAPE_BAD_SUM) begin
			frame_q[frame_q.size() - 1 - $urandom_range(0, 1)] ^= BYTE_W'(1 << $urandom_range(0, 7));
		end else if (shape == SHAPE_CUT) begin
			cut = $urandom_range(1, frame_q.size() - 1);
			while (frame_q.size() > cut) void'(frame_q.pop_back());
		end
	endfunction

	// Sends one byte after an optional gap and notes it once the transaction completes.
	task automatic send_byte(input logic [BYTE_W-1:0] value, input logic last, input int gap);
		@(negedge clk);
		if (gap > 0) begin
			bytes_ch.valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		bytes_ch.valid      <= 1'b1;
		bytes_ch.byte_value <= value;
		bytes_ch.frame_end  <= last;
		do @(posedge clk); while (!bytes_ch.ready);
		outcomes.take_byte(value, last);
	endtask

	task automatic send_frame();
		quiet = ($urandom_range(0, 7) == 0);
		foreach (frame_q[i]) begin
			send_byte(frame_q[i], i == frame_q.size() - 1, quiet ? 0 : idle_length());
		end
	endtask

	// Waits until every awaited result has come and the block has settled.
	task automatic drain();
		@(negedge clk);
		bytes_ch.valid <= 1'b0;
		while (outcomes.pending_count() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_reg(input logic [CFG_INDEX_W-1:0] index,
			input logic [CFG_DATA_W-1:0] data);
		@(negedge clk);
		cfg_ch.valid <= 1'b1;
		cfg_ch.index <= index;
		cfg_ch.data  <= data;
		do @(posedge clk); while (!cfg_ch.ready);
		outcomes.write_register(index, data);
		@(negedge clk);
		cfg_ch.valid <= 1'b0;
	endtask

	// One register setting followed by random datagrams until the byte budget is spent.
	task automatic run_phase(input logic [MAGIC_W-1:0] magic, input logic [CFG_DATA_W-1:0] max_data,
			input int budget);
		int sent;
		write_reg(REG_MAGIC_WORD, magic);
		write_reg(REG_MAX_DATAGRAM, max_data);
		cur_magic = magic;
		settings_used++;
		sent = 0;
		while (sent < budget) begin
			build_frame();
			send_frame();
			sent += frame_q.size();
		end
		drain();
	endtask

	// Result side: random stalls, check at each completed transaction.
	initial begin : result_sink
		int           stall_left;
		lfpc_result_t got;
		stall_left = 0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (stall_left > 0) begin
				result_ch.ready <= 1'b0;
				stall_left--;
			end else begin
				result_ch.ready <= 1'b1;
				if (!quiet && $urandom_range(0, 3) == 0) stall_left = idle_length();
			end
			@(posedge clk);
			if (result_ch.valid === 1'b1 && result_ch.ready === 1'b1) begin
				got.kind            = result_ch.kind;
				got.data_byte       = result_ch.data_byte;
				got.msg_ident       = result_ch.msg_ident;
				got.sequence_number = result_ch.sequence_number;
				got.payload_length  = result_ch.payload_length;
				got.status          = result_ch.status;
				outcomes.compare_result(got);
			end
		end
	end

	// Stimulus and end of run.
	initial begin : stimulus
		int waited;
		outcomes = new();
		arst_n              = 1'b0;
		bytes_ch.valid      = 1'b0;
		bytes_ch.byte_value = '0;
		bytes_ch.frame_end  = 1'b0;
		cfg_ch.valid        = 1'b0;
		cfg_ch.index        = REG_MAGIC_WORD;
		cfg_ch.data         = '0;
		result_ch.ready     = 1'b0;
		cur_magic           = MAGIC_RESET;
		quiet               = 1'b0;
		settings_used       = 1;
		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// Directed frames under the reset settings: an all-zero minimal frame,
		// a single-byte frame, and a frame with extreme header fields and one payload byte.
		frame_q.delete();
		repeat (14) add_byte(8'h00);
		send_frame();
		frame_q = '{8'hFF};
		send_frame();
		frame_q = '{8'h00, 8'h00, 8'h00, 8'h00, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF,
			8'h01, 8'h00, 8'hFF};
		append_checksum();
		send_frame();
		drain();

		// Random phases across the register range, extremes included.
		run_phase($urandom, {16'($urandom), 16'hFFFF}, 450);
		run_phase('1, CFG_DATA_W'(14), 300);
		run_phase('0, '0, 150);
		run_phase($urandom, CFG_DATA_W'($urandom_range(14, 200)), 450);
		run_phase('0, CFG_DATA_W'(65507), 320);

		// Final wait for stragglers, bounded.
		waited = 0;
		while (outcomes.pending_count() != 0 && waited < 10000) begin
			@(posedge clk);
			waited++;
		end
		repeat (8) @(posedge clk);
		outcomes.flush_leftovers();

		$display("Checked %0d payload bytes over %0d register settings.",
			outcomes.payload_seen, settings_used);
		$display("Verdicts: ok %0d, short %0d, long %0d, magic %0d, length %0d, checksum %0d.",
			outcomes.verdict_tally[STATUS_OK], outcomes.verdict_tally[STATUS_SHORT],
			outcomes.verdict_tally[STATUS_LONG], outcomes.verdict_tally[STATUS_BAD_MAGIC],
			outcomes.verdict_tally[STATUS_LENGTH], outcomes.verdict_tally[STATUS_CHECKSUM]);
		if (outcomes.failures == 0) begin
			$display("All tests passed");
		end else begin
			$display("Some tests failed");
		end
		$finish;
	end

endmodule
